// ===== design/mtd_pkg.sv =====
// Shared types, character codes and the Morse lookup table for the token decoder.
`timescale 1ns / 1ps

package mtd_pkg;

	localparam int unsigned SYM_MAX = 5;
	localparam int unsigned CNT_W   = 3;

	localparam logic [7:0] CHAR_DOT     = 8'h2E;
	localparam logic [7:0] CHAR_DASH    = 8'h2D;
	localparam logic [7:0] CHAR_SLASH   = 8'h2F;
	localparam logic [7:0] CHAR_SPACE   = 8'h20;
	localparam logic [7:0] CHAR_UNKNOWN = 8'h3F;
	localparam logic [7:0] CHAR_TAB     = 8'h09;
	localparam logic [7:0] CHAR_CR      = 8'h0D;
	localparam logic [7:0] CHAR_NONE    = 8'h00;

	typedef struct packed {
		logic [SYM_MAX-1:0] pattern;
		logic [CNT_W-1:0]   count;
		logic               in_token;
		logic               invalid;
		logic               slash;
	} token_t;

	// key is a leading marker bit above the dash/dot pattern; 0 means no entry
	function automatic logic [7:0] code_lookup(input logic [SYM_MAX:0] key);
		logic [7:0] ch;
		ch = CHAR_NONE;
		case (key)
			6'h05: ch = "A";
			6'h18: ch = "B";
			6'h1A: ch = "C";
			6'h0C: ch = "D";
			6'h02: ch = "E";
			6'h12: ch = "F";
			6'h0E: ch = "G";
			6'h10: ch = "H";
			6'h04: ch = "I";
			6'h17: ch = "J";
			6'h0D: ch = "K";
			6'h14: ch = "L";
			6'h07: ch = "M";
			6'h06: ch = "N";
			6'h0F: ch = "O";
			6'h16: ch = "P";
			6'h1D: ch = "Q";
			6'h0A: ch = "R";
			6'h08: ch = "S";
			6'h03: ch = "T";
			6'h09: ch = "U";
			6'h11: ch = "V";
			6'h0B: ch = "W";
			6'h19: ch = "X";
			6'h1B: ch = "Y";
			6'h1C: ch = "Z";
			6'h3F: ch = "0";
			6'h2F: ch = "1";
			6'h27: ch = "2";
			6'h23: ch = "3";
			6'h21: ch = "4";
			6'h20: ch = "5";
			6'h30: ch = "6";
			6'h38: ch = "7";
			6'h3C: ch = "8";
			6'h3E: ch = "9";
			default: ch = CHAR_NONE;
		endcase
		return ch;
	endfunction

endpackage

// ===== design/mtd_token_eval.sv =====
// Maps a finished token to its output character and unrecognized flag.
`timescale 1ns / 1ps

module mtd_token_eval (
	input  mtd_pkg::token_t tok,
	output logic [7:0]      text_char,
	output logic            unrecognized
);

	logic [mtd_pkg::SYM_MAX:0] key;
	logic [7:0]                ch;

	always_comb begin
		key = (mtd_pkg::SYM_MAX+1)'(1) << tok.count;
		key = key | {1'b0, tok.pattern};
		ch  = mtd_pkg::CHAR_NONE;
		if (!tok.invalid) begin
			if (tok.slash) begin
				ch = mtd_pkg::CHAR_SPACE;
			end else begin
				ch = mtd_pkg::code_lookup(key);
			end
		end
		if (ch == mtd_pkg::CHAR_NONE) begin
			text_char    = mtd_pkg::CHAR_UNKNOWN;
			unrecognized = 1'b1;
		end else begin
			text_char    = ch;
			unrecognized = 1'b0;
		end
	end

endmodule

// ===== design/morse_token_decoder.sv =====
// Top level of the Morse token decoder: input stage, token state and result register.
`timescale 1ns / 1ps

// Morse text decoder.
// s_* carries one ASCII byte of Morse text per word; s_tlast marks the final
// byte of a message and flushes any pending token. m_* carries one decoded
// character per word, with m_tuser set when the token was not recognized
// ('?' is sent). Whitespace ends a token; "/" decodes to a space.
// Each input word is registered, then token tracking and the table match run
// in one pass into the result register. A word that ends a token passes
// through the input register and then the result register to m_*. One word
// is taken per cycle when the receiver keeps up, also words that emit nothing.
// When m_tready is low with a result pending, the input stage holds one more
// word and then s_tready drops until the result is taken.
// Reset clears the token state and both stages; nothing is pending after it.
module morse_token_decoder (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] code_char
	input  logic       s_tlast,
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [7:0] text_char
	output logic       m_tuser    // [0] unrecognized
);

	logic       valid_s1;
	logic [7:0] char_s1;
	logic       last_s1;

	mtd_pkg::token_t tok_q, tok_upd, tok_eval, tok_nxt;

	logic       out_free;
	logic       adv;
	logic       is_space;
	logic       emit;
	logic [7:0] eval_char;
	logic       eval_unrec;

	logic       m_valid_q;
	logic [7:0] m_data_q;
	logic       m_user_q;

	assign out_free = !m_valid_q || m_tready;
	assign s_tready = !valid_s1 || out_free;
	assign adv      = valid_s1 && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			char_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	always_comb begin
		is_space = (char_s1 == mtd_pkg::CHAR_SPACE) ||
			(char_s1 >= mtd_pkg::CHAR_TAB && char_s1 <= mtd_pkg::CHAR_CR);

		tok_upd = tok_q;
		if (char_s1 == mtd_pkg::CHAR_DOT || char_s1 == mtd_pkg::CHAR_DASH) begin
			if (tok_q.slash) begin
				tok_upd.invalid = 1'b1;
			end else if (tok_q.count >= mtd_pkg::CNT_W'(mtd_pkg::SYM_MAX)) begin
				tok_upd.invalid = 1'b1;
			end else begin
				tok_upd.pattern = {tok_q.pattern[mtd_pkg::SYM_MAX-2:0],
					char_s1 == mtd_pkg::CHAR_DASH};
				tok_upd.count   = tok_q.count + mtd_pkg::CNT_W'(1);
			end
		end else if (char_s1 == mtd_pkg::CHAR_SLASH) begin
			if (tok_q.in_token) begin
				tok_upd.invalid = 1'b1;
			end else begin
				tok_upd.slash = 1'b1;
			end
		end else begin
			tok_upd.invalid = 1'b1;
		end
		tok_upd.in_token = 1'b1;

		tok_eval = is_space ? tok_q : tok_upd;
		emit     = is_space ? tok_q.in_token : last_s1;
		tok_nxt  = emit ? '0 : tok_eval;
	end

	mtd_token_eval u_eval (
		.tok          (tok_eval),
		.text_char    (eval_char),
		.unrecognized (eval_unrec)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else if (adv) begin
			tok_q <= tok_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (out_free) begin
			m_valid_q <= adv && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && emit) begin
			m_data_q <= eval_char;
			m_user_q <= eval_unrec;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;
	assign m_tuser  = m_user_q;

endmodule
